// ===== design/sdf_pkg.sv =====
// sdf_pkg: widths and transaction side-band types for the segment distance falloff block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package sdf_pkg;

  // Field widths
  localparam int COORD_W = 16;                 // signed Q4.12 coordinates
  localparam int BLUR_W  = 15;                 // unsigned Q3.12 blur radius
  localparam int DIFF_W  = COORD_W + 1;        // coordinate differences
  localparam int PROD_W  = 2 * DIFF_W;         // products and sums of squares
  localparam int T_BITS  = 16;                 // projection parameter fraction bits
  localparam int T_W     = T_BITS + 1;         // t in [0, 1.0]
  localparam int DIST_W  = 17;                 // unsigned Q5.12 distance
  localparam int CLOSE_W = 17;                 // Q0.16 closeness, 1.0 included
  localparam int RDIV_W  = BLUR_W + 1;         // divisor of the closeness ratio
  localparam int NUM_W   = DIST_W + T_BITS + 1; // ratio numerator

  localparam logic [T_W-1:0]     T_ONE     = T_W'(1) << T_BITS;
  localparam logic [CLOSE_W-1:0] CLOSE_ONE = CLOSE_W'(1) << T_BITS;

  // Side-band that rides along with the projection divider
  typedef struct packed {
    logic                      t_lo;
    logic                      t_hi;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [BLUR_W-1:0]         blur;
  } proj_side_t;

  // Side-band that rides along with the closeness divider
  typedef struct packed {
    logic              ok;
    logic [DIST_W-1:0] distance;
  } close_side_t;

endpackage

// ===== design/sdf_divider.sv =====
// sdf_divider: pipelined restoring divider, one quotient bit per register stage.
// Generic; no package dependencies.
`timescale 1ns / 1ps

module sdf_divider #(
  parameter int DIV_W  = 16,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  logic [DIV_W-1:0]  rem_i,   // partial remainder, must be below div_i
  input  logic [DIV_W-1:0]  div_i,
  input  logic [Q_W-1:0]    low_i,   // dividend bits shifted in, MSB first
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_in  [0:Q_W-1];
  logic [DIV_W-1:0]  rem_in  [0:Q_W-1];
  logic [DIV_W-1:0]  div_in  [0:Q_W-1];
  logic [Q_W-1:0]    low_in  [0:Q_W-1];
  logic [Q_W-1:0]    quot_in [0:Q_W-1];
  logic [SIDE_W-1:0] side_in [0:Q_W-1];

  logic              vld_r   [0:Q_W-1];
  logic [DIV_W-1:0]  rem_r   [0:Q_W-1];
  logic [DIV_W-1:0]  div_r   [0:Q_W-1];
  logic [Q_W-1:0]    low_r   [0:Q_W-1];
  logic [Q_W-1:0]    quot_r  [0:Q_W-1];
  logic [SIDE_W-1:0] side_r  [0:Q_W-1];

  // Feed the first stage from the ports
  assign vld_in[0]  = valid_i;
  assign rem_in[0]  = rem_i;
  assign div_in[0]  = div_i;
  assign low_in[0]  = low_i;
  assign quot_in[0] = '0;
  assign side_in[0] = side_i;

  genvar i;
  generate
    for (i = 0; i < Q_W; i++) begin : g_stage
      logic [DIV_W:0] part;
      logic [DIV_W:0] diff;
      logic           ge;

      if (i > 0) begin : g_link
        assign vld_in[i]  = vld_r[i-1];
        assign rem_in[i]  = rem_r[i-1];
        assign div_in[i]  = div_r[i-1];
        assign low_in[i]  = low_r[i-1];
        assign quot_in[i] = quot_r[i-1];
        assign side_in[i] = side_r[i-1];
      end

      // Shift in the next dividend bit and try one subtraction
      assign part = {rem_in[i], low_in[i][Q_W-1]};
      assign diff = part - {1'b0, div_in[i]};
      assign ge   = (part >= {1'b0, div_in[i]});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else begin
          vld_r[i] <= vld_in[i];
        end
      end

      always_ff @(posedge clk) begin
        rem_r[i]  <= ge ? diff[DIV_W-1:0] : part[DIV_W-1:0];
        div_r[i]  <= div_in[i];
        low_r[i]  <= {low_in[i][Q_W-2:0], 1'b0};
        quot_r[i] <= {quot_in[i][Q_W-2:0], ge};
        side_r[i] <= side_in[i];
      end
    end
  endgenerate

  assign valid_o = vld_r[Q_W-1];
  assign quot_o  = quot_r[Q_W-1];
  assign side_o  = side_r[Q_W-1];

endmodule

// ===== design/sdf_sqrt.sv =====
// sdf_sqrt: pipelined integer square root, one root bit per stage, rounded to nearest.
// Generic; no package dependencies.
`timescale 1ns / 1ps

module sdf_sqrt #(
  parameter int ROOT_W = 17,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  logic [2*ROOT_W-1:0] rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int REM_W = ROOT_W + 2;

  logic                vld_in  [0:ROOT_W-1];
  logic [2*ROOT_W-1:0] rad_in  [0:ROOT_W-1];
  logic [REM_W-1:0]    rem_in  [0:ROOT_W-1];
  logic [ROOT_W-1:0]   root_in [0:ROOT_W-1];
  logic [SIDE_W-1:0]   side_in [0:ROOT_W-1];

  logic                vld_r   [0:ROOT_W-1];
  logic [2*ROOT_W-1:0] rad_r   [0:ROOT_W-1];
  logic [REM_W-1:0]    rem_r   [0:ROOT_W-1];
  logic [ROOT_W-1:0]   root_r  [0:ROOT_W-1];
  logic [SIDE_W-1:0]   side_r  [0:ROOT_W-1];

  logic                out_vld_r;
  logic [ROOT_W-1:0]   out_root_r;
  logic [SIDE_W-1:0]   out_side_r;
  logic                round_up;

  assign vld_in[0]  = valid_i;
  assign rad_in[0]  = rad_i;
  assign rem_in[0]  = '0;
  assign root_in[0] = '0;
  assign side_in[0] = side_i;

  genvar i;
  generate
    for (i = 0; i < ROOT_W; i++) begin : g_stage
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] trial;
      logic             ge;

      if (i > 0) begin : g_link
        assign vld_in[i]  = vld_r[i-1];
        assign rad_in[i]  = rad_r[i-1];
        assign rem_in[i]  = rem_r[i-1];
        assign root_in[i] = root_r[i-1];
        assign side_in[i] = side_r[i-1];
      end

      // Bring down the next bit pair and try root*4+1
      assign shifted = {rem_in[i][REM_W-3:0], rad_in[i][2*ROOT_W-1-2*i -: 2]};
      assign trial   = {root_in[i], 2'b01};
      assign ge      = (shifted >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else begin
          vld_r[i] <= vld_in[i];
        end
      end

      always_ff @(posedge clk) begin
        rad_r[i]  <= rad_in[i];
        rem_r[i]  <= ge ? (shifted - trial) : shifted;
        root_r[i] <= {root_in[i][ROOT_W-2:0], ge};
        side_r[i] <= side_in[i];
      end
    end
  endgenerate

  // Round up when the leftover exceeds the root
  assign round_up = (rem_r[ROOT_W-1] > {2'b00, root_r[ROOT_W-1]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    out_root_r <= root_r[ROOT_W-1] + ROOT_W'(round_up);
    out_side_r <= side_r[ROOT_W-1];
  end

  assign valid_o = out_vld_r;
  assign root_o  = out_root_r;
  assign side_o  = out_side_r;

endmodule

// ===== design/segment_distance_falloff_top.sv =====
// segment_distance_falloff_top: point to segment distance with linear closeness falloff.
// Depends on sdf_pkg, sdf_divider and sdf_sqrt.
`timescale 1ns / 1ps

// The block takes one transaction per clock: start is honored in every cycle and
// busy stays low. Each transaction yields exactly one result, shown on the out_
// ports for one cycle with out_valid high. The pipeline is made of the two 16-step
// dividers (projection parameter and closeness ratio) and the 17-step square root,
// each taking one register stage per step, plus twelve stages of difference,
// multiply, rounding and output logic. Results leave in order; there is no way to
// hold them back.
module segment_distance_falloff_top
  import sdf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_y,
  input  logic [BLUR_W-1:0]         in_blur_radius,
  output logic                      out_valid,
  output logic [DIST_W-1:0]         out_distance,
  output logic [CLOSE_W-1:0]        out_closeness
);

  localparam int LATENCY = 4 + T_BITS + 5 + (DIST_W + 1) + 1 + T_BITS + 1;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- stage 1: differences ----------------
  logic                      s1_vld_r;
  logic signed [COORD_W-1:0] s1_px_r, s1_py_r, s1_sx_r, s1_sy_r;
  logic signed [DIFF_W-1:0]  s1_dx_r, s1_dy_r, s1_ux_r, s1_uy_r;
  logic [BLUR_W-1:0]         s1_blur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_px_r   <= in_point_x;
    s1_py_r   <= in_point_y;
    s1_sx_r   <= in_start_x;
    s1_sy_r   <= in_start_y;
    s1_dx_r   <= DIFF_W'(in_end_x) - DIFF_W'(in_start_x);
    s1_dy_r   <= DIFF_W'(in_end_y) - DIFF_W'(in_start_y);
    s1_ux_r   <= DIFF_W'(in_point_x) - DIFF_W'(in_start_x);
    s1_uy_r   <= DIFF_W'(in_point_y) - DIFF_W'(in_start_y);
    s1_blur_r <= in_blur_radius;
  end

  // ---------------- stage 2: products ----------------
  logic                      s2_vld_r;
  logic signed [COORD_W-1:0] s2_px_r, s2_py_r, s2_sx_r, s2_sy_r;
  logic signed [DIFF_W-1:0]  s2_dx_r, s2_dy_r;
  logic signed [PROD_W-1:0]  s2_dxx_r, s2_dyy_r, s2_uxd_r, s2_uyd_r;
  logic [BLUR_W-1:0]         s2_blur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_px_r   <= s1_px_r;
    s2_py_r   <= s1_py_r;
    s2_sx_r   <= s1_sx_r;
    s2_sy_r   <= s1_sy_r;
    s2_dx_r   <= s1_dx_r;
    s2_dy_r   <= s1_dy_r;
    s2_dxx_r  <= s1_dx_r * s1_dx_r;
    s2_dyy_r  <= s1_dy_r * s1_dy_r;
    s2_uxd_r  <= s1_ux_r * s1_dx_r;
    s2_uyd_r  <= s1_uy_r * s1_dy_r;
    s2_blur_r <= s1_blur_r;
  end

  // ---------------- stage 3: squared length and dot product ----------------
  logic                      s3_vld_r;
  logic signed [COORD_W-1:0] s3_px_r, s3_py_r, s3_sx_r, s3_sy_r;
  logic signed [DIFF_W-1:0]  s3_dx_r, s3_dy_r;
  logic [PROD_W-1:0]         s3_len2_r;
  logic signed [PROD_W-1:0]  s3_num_r;
  logic [BLUR_W-1:0]         s3_blur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_px_r   <= s2_px_r;
    s3_py_r   <= s2_py_r;
    s3_sx_r   <= s2_sx_r;
    s3_sy_r   <= s2_sy_r;
    s3_dx_r   <= s2_dx_r;
    s3_dy_r   <= s2_dy_r;
    s3_len2_r <= $unsigned(s2_dxx_r + s2_dyy_r);
    s3_num_r  <= s2_uxd_r + s2_uyd_r;
    s3_blur_r <= s2_blur_r;
  end

  // ---------------- stage 4: clamp classification ----------------
  logic              s4_vld_r;
  proj_side_t        s4_side_r;
  logic [PROD_W-1:0] s4_rem_r;
  logic [PROD_W-1:0] s4_len2_r;
  logic              t_lo_nxt, t_hi_nxt;

  // t clamps to zero for a degenerate segment or a point behind the start
  assign t_lo_nxt = (s3_len2_r == '0) || s3_num_r[PROD_W-1] || (s3_num_r == '0);
  assign t_hi_nxt = !t_lo_nxt && ($unsigned(s3_num_r) >= s3_len2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_side_r.t_lo <= t_lo_nxt;
    s4_side_r.t_hi <= t_hi_nxt;
    s4_side_r.px   <= s3_px_r;
    s4_side_r.py   <= s3_py_r;
    s4_side_r.sx   <= s3_sx_r;
    s4_side_r.sy   <= s3_sy_r;
    s4_side_r.dx   <= s3_dx_r;
    s4_side_r.dy   <= s3_dy_r;
    s4_side_r.blur <= s3_blur_r;
    s4_rem_r       <= (t_lo_nxt || t_hi_nxt) ? '0 : $unsigned(s3_num_r);
    s4_len2_r      <= s3_len2_r;
  end

  // ---------------- projection divider: t = num * 2^16 / len2 ----------------
  logic              pd_vld;
  logic [T_BITS-1:0] pd_quot;
  proj_side_t        pd_side;

  sdf_divider #(
    .DIV_W  (PROD_W),
    .Q_W    (T_BITS),
    .SIDE_W ($bits(proj_side_t))
  ) u_proj_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s4_vld_r),
    .rem_i   (s4_rem_r),
    .div_i   (s4_len2_r),
    .low_i   ('0),
    .side_i  (s4_side_r),
    .valid_o (pd_vld),
    .quot_o  (pd_quot),
    .side_o  (pd_side)
  );

  // ---------------- stage 5: clamp t ----------------
  logic                      s5_vld_r;
  logic [T_W-1:0]            s5_t_r;
  logic signed [COORD_W-1:0] s5_px_r, s5_py_r, s5_sx_r, s5_sy_r;
  logic signed [DIFF_W-1:0]  s5_dx_r, s5_dy_r;
  logic [BLUR_W-1:0]         s5_blur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= pd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pd_side.t_lo) begin
      s5_t_r <= '0;
    end else if (pd_side.t_hi) begin
      s5_t_r <= T_ONE;
    end else begin
      s5_t_r <= {1'b0, pd_quot};
    end
    s5_px_r   <= pd_side.px;
    s5_py_r   <= pd_side.py;
    s5_sx_r   <= pd_side.sx;
    s5_sy_r   <= pd_side.sy;
    s5_dx_r   <= pd_side.dx;
    s5_dy_r   <= pd_side.dy;
    s5_blur_r <= pd_side.blur;
  end

  // ---------------- stage 6: scale direction by t ----------------
  localparam int MT_W = T_W + 1 + DIFF_W;

  logic                      s6_vld_r;
  logic signed [MT_W-1:0]    s6_mx_r, s6_my_r;
  logic signed [COORD_W-1:0] s6_px_r, s6_py_r, s6_sx_r, s6_sy_r;
  logic [BLUR_W-1:0]         s6_blur_r;
  logic signed [T_W:0]       t_sgn;

  assign t_sgn = $signed({1'b0, s5_t_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_mx_r   <= t_sgn * s5_dx_r;
    s6_my_r   <= t_sgn * s5_dy_r;
    s6_px_r   <= s5_px_r;
    s6_py_r   <= s5_py_r;
    s6_sx_r   <= s5_sx_r;
    s6_sy_r   <= s5_sy_r;
    s6_blur_r <= s5_blur_r;
  end

  // ---------------- stage 7: projected point and residual ----------------
  localparam int R_W = DIFF_W + 1;

  logic                     s7_vld_r;
  logic signed [DIFF_W-1:0] s7_rx_r, s7_ry_r;
  logic [BLUR_W-1:0]        s7_blur_r;
  logic signed [MT_W-1:0]   mx_rnd, my_rnd;
  logic signed [R_W-1:0]    qx, qy, rx_nxt, ry_nxt;

  // Round half up, then offset from the start point
  assign mx_rnd = s6_mx_r + MT_W'(1 << (T_BITS - 1));
  assign my_rnd = s6_my_r + MT_W'(1 << (T_BITS - 1));
  assign qx     = R_W'(s6_sx_r) + R_W'(mx_rnd[T_BITS +: DIFF_W]);
  assign qy     = R_W'(s6_sy_r) + R_W'(my_rnd[T_BITS +: DIFF_W]);
  assign rx_nxt = R_W'(s6_px_r) - qx;
  assign ry_nxt = R_W'(s6_py_r) - qy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_rx_r   <= rx_nxt[DIFF_W-1:0];
    s7_ry_r   <= ry_nxt[DIFF_W-1:0];
    s7_blur_r <= s6_blur_r;
  end

  // ---------------- stage 8: squares ----------------
  logic                     s8_vld_r;
  logic signed [PROD_W-1:0] s8_rxx_r, s8_ryy_r;
  logic [BLUR_W-1:0]        s8_blur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_vld_r <= 1'b0;
    end else begin
      s8_vld_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s8_rxx_r  <= s7_rx_r * s7_rx_r;
    s8_ryy_r  <= s7_ry_r * s7_ry_r;
    s8_blur_r <= s7_blur_r;
  end

  // ---------------- stage 9: sum of squares ----------------
  logic              s9_vld_r;
  logic [PROD_W-1:0] s9_sum_r;
  logic [BLUR_W-1:0] s9_blur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else begin
      s9_vld_r <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s9_sum_r  <= $unsigned(s8_rxx_r + s8_ryy_r);
    s9_blur_r <= s8_blur_r;
  end

  // ---------------- square root ----------------
  logic              sq_vld;
  logic [DIST_W-1:0] sq_root;
  logic [BLUR_W-1:0] sq_blur;

  sdf_sqrt #(
    .ROOT_W (DIST_W),
    .SIDE_W (BLUR_W)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s9_vld_r),
    .rad_i   (s9_sum_r),
    .side_i  (s9_blur_r),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_blur)
  );

  // ---------------- stage 10: closeness ratio setup ----------------
  logic              s10_vld_r;
  close_side_t       s10_side_r;
  logic [RDIV_W-1:0] s10_rem_r, s10_div_r;
  logic [T_BITS-1:0] s10_low_r;
  logic              ok_nxt;
  logic [NUM_W-1:0]  rnum;

  // Ratio is (dist * 2^17 + blur) / (2 * blur), only inside the radius
  assign ok_nxt = (sq_blur != '0) && (sq_root < DIST_W'(sq_blur));
  assign rnum   = {sq_root, {(T_BITS + 1){1'b0}}} + NUM_W'(sq_blur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_vld_r <= 1'b0;
    end else begin
      s10_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    s10_side_r.ok       <= ok_nxt;
    s10_side_r.distance <= sq_root;
    s10_rem_r           <= ok_nxt ? rnum[T_BITS +: RDIV_W] : '0;
    s10_low_r           <= rnum[T_BITS-1:0];
    s10_div_r           <= {sq_blur, 1'b0};
  end

  // ---------------- closeness divider ----------------
  logic              cd_vld;
  logic [T_BITS-1:0] cd_quot;
  close_side_t       cd_side;

  sdf_divider #(
    .DIV_W  (RDIV_W),
    .Q_W    (T_BITS),
    .SIDE_W ($bits(close_side_t))
  ) u_close_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s10_vld_r),
    .rem_i   (s10_rem_r),
    .div_i   (s10_div_r),
    .low_i   (s10_low_r),
    .side_i  (s10_side_r),
    .valid_o (cd_vld),
    .quot_o  (cd_quot),
    .side_o  (cd_side)
  );

  // ---------------- stage 11: output register ----------------
  logic               out_vld_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic [CLOSE_W-1:0] out_close_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= cd_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_dist_r  <= cd_side.distance;
    out_close_r <= cd_side.ok ? (CLOSE_ONE - CLOSE_W'(cd_quot)) : '0;
  end

  assign out_valid     = out_vld_r;
  assign out_distance  = out_dist_r;
  assign out_closeness = out_close_r;

  // ---------------- assertions ----------------
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("transaction did not produce a result on time");

  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without a matching transaction");

  a_close_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_closeness <= CLOSE_ONE))
    else $error("closeness above one");

  a_full_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_closeness == CLOSE_ONE)) |-> (out_distance == '0))
    else $error("full closeness with nonzero distance");

endmodule

// ===== tb/sdf_checker.sv =====
// sdf_checker: predicts distance and closeness for every accepted transaction and
// compares each strobed result with the oldest prediction. Depends on sdf_pkg.
`timescale 1ns / 1ps

module sdf_checker
  import sdf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_start_x,
  input  logic signed [COORD_W-1:0] in_start_y,
  input  logic signed [COORD_W-1:0] in_end_x,
  input  logic signed [COORD_W-1:0] in_end_y,
  input  logic [BLUR_W-1:0]         in_blur_radius,
  input  logic                      out_valid,
  input  logic [DIST_W-1:0]         out_distance,
  input  logic [CLOSE_W-1:0]        out_closeness,
  output int                        fail_count,
  output int                        pending_count
);

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [CLOSE_W-1:0] close;
  } falloff_t;

  falloff_t expected_q[$];

  // Rounded integer square root
  function automatic longint unsigned root_nearest(longint unsigned n);
    longint unsigned r;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    r = lo;
    if (n - r * r > r) r++;
    return r;
  endfunction

  // Round a t-scaled product back to coordinate scale, ties upward
  function automatic longint scale_down(longint v);
    longint a;
    a = v + 32768;
    if (a >= 0) return a >>> 16;
    return -((-a + 65535) >>> 16);
  endfunction

  function automatic falloff_t falloff_of(longint px, longint py, longint sx, longint sy,
                                          longint ex, longint ey,
                                          longint unsigned blur);
    longint dx, dy, len2, qx, qy, num, t, rx, ry;
    longint unsigned root, ratio, close;
    falloff_t res;
    dx = ex - sx;
    dy = ey - sy;
    len2 = dx * dx + dy * dy;
    qx = sx;
    qy = sy;
    if (len2 != 0) begin
      num = (px - sx) * dx + (py - sy) * dy;
      if (num <= 0) t = 0;
      else if (num >= len2) t = 65536;
      else t = (num * 65536) / len2;
      if (t >= 65536) begin
        qx = ex;
        qy = ey;
      end else if (t > 0) begin
        qx = sx + scale_down(t * dx);
        qy = sy + scale_down(t * dy);
      end
    end
    rx = px - qx;
    ry = py - qy;
    root = root_nearest(longint'(rx * rx + ry * ry));
    close = 0;
    if (blur != 0 && root < blur) begin
      ratio = ((root << 17) + blur) / (blur << 1);
      close = (ratio >= 65536) ? 0 : 65536 - ratio;
    end
    res.distance = DIST_W'(root);
    res.close = CLOSE_W'(close);
    return res;
  endfunction

  assign pending_count = expected_q.size();

  // Predict on accepted transactions, compare on strobed results
  always @(posedge clk) begin
    falloff_t want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (start && !busy)
        expected_q.push_back(falloff_of(in_point_x, in_point_y, in_start_x, in_start_y,
                                        in_end_x, in_end_y, in_blur_radius));
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result dist=%0d close=%0d",
                                        out_distance, out_closeness);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.distance !== out_distance || want.close !== out_closeness) begin
            if (fail_count < 10)
              $display("mismatch: dist exp %0d got %0d, close exp %0d got %0d",
                       want.distance, out_distance, want.close, out_closeness);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// tb: drives directed and random transactions into segment_distance_falloff_top and
// gives the verdict. Depends on sdf_pkg, sdf_checker and the block.
`timescale 1ns / 1ps

module tb;
  import sdf_pkg::*;

  localparam int LATENCY = 61;
  localparam int WATCHDOG = 2000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [COORD_W-1:0] px = 0, py = 0, sx = 0, sy = 0, ex = 0, ey = 0;
  logic [BLUR_W-1:0] blur = 0;
  logic out_valid;
  logic [DIST_W-1:0] out_distance;
  logic [CLOSE_W-1:0] out_closeness;
  int fail_count;
  int pending_count;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  segment_distance_falloff_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(px), .in_point_y(py), .in_start_x(sx), .in_start_y(sy),
    .in_end_x(ex), .in_end_y(ey), .in_blur_radius(blur),
    .out_valid(out_valid), .out_distance(out_distance), .out_closeness(out_closeness)
  );

  sdf_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_point_x(px), .in_point_y(py), .in_start_x(sx), .in_start_y(sy),
    .in_end_x(ex), .in_end_y(ey), .in_blur_radius(blur),
    .out_valid(out_valid), .out_distance(out_distance), .out_closeness(out_closeness),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Count cycles with no accepted transaction and no result; end the run if they pile up
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one transaction, holding start until accepted
  task automatic send_segment(input logic [15:0] qx, qy, ax, ay, bx, by,
                              input logic [14:0] r, input int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    px <= qx; py <= qy; sx <= ax; sy <= ay; ex <= bx; ey <= by; blur <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] pick_blur();
    case ($urandom_range(5))
      0: return 15'd0;
      1: return 15'h7fff;
      2: return 15'($urandom_range(4096));
      default: return 15'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count, input int gap_pct);
    logic [15:0] ax, ay;
    for (int i = 0; i < count; i++) begin
      ax = pick_coord();
      ay = pick_coord();
      // Mix in zero-length and short segments
      if ($urandom_range(9) == 0)
        send_segment(pick_coord(), pick_coord(), ax, ay, ax, ay, pick_blur(), gap_pct);
      else if ($urandom_range(3) == 0)
        send_segment(ax + 16'($urandom_range(4095)) - 16'd2048,
                     ay + 16'($urandom_range(4095)) - 16'd2048, ax, ay,
                     ax + 16'($urandom_range(511)) - 16'd256,
                     ay + 16'($urandom_range(511)) - 16'd256, pick_blur(), gap_pct);
      else
        send_segment(pick_coord(), pick_coord(), ax, ay, pick_coord(), pick_coord(),
                     pick_blur(), gap_pct);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // Directed: extremes, zero-length segment, clamp at both ends, blur cases
    send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 15'h7fff, 0);
    send_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 15'd0, 0);
    send_segment(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'd4096, 0);
    send_segment(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'd0, 0);
    send_segment(16'hf000, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 15'd8192, 0);
    send_segment(16'h3000, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 15'd8192, 0);
    send_segment(16'h0800, 16'h0800, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 15'd2048, 0);
    send_segment(16'h0800, 16'h0800, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 15'd2047, 0);
    send_segment(16'h0800, 16'h0800, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 15'd2049, 0);
    send_segment(16'h0800, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 15'd1, 0);
    send_segment(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 15'h7fff, 0);
    send_segment(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 15'h7fff, 0);
    send_segment(16'h0001, 16'h0003, 16'h0000, 16'h0000, 16'h0003, 16'h0007, 15'd5, 0);
    send_segment(16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'hfffd, 16'h0002, 15'd3, 0);
    send_segment(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 15'h4000, 0);
    random_phase(580, 22);
    random_phase(580, 47);
    random_phase(590, 0);
    start <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/sdf_pkg.sv
design/sdf_divider.sv
design/sdf_sqrt.sv
design/segment_distance_falloff_top.sv
tb/sdf_checker.sv
tb/tb.sv
